// File: design/uart_tx_rx_ring_buffers_unit_defines.svh
// Assertion macros shared by the ring buffer unit RTL.
`ifndef UART_TX_RX_RING_BUFFERS_UNIT_DEFINES_SVH
`define UART_TX_RX_RING_BUFFERS_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define UTRB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utrb assertion failed");

// Next-cycle implication, checked on every clk edge outside reset.
`define UTRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utrb assertion failed");

`endif

// File: design/utrb_pkg.sv
// Types, constants and helpers for the UART ring buffer unit.
package utrb_pkg;

  localparam int DEPTH = 128;
  localparam int PTR_W = $clog2(DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t LAST_POS = ptr_t'(DEPTH - 1);

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_READ = 2'd1,
    CMD_TICK = 2'd2,
    CMD_RECV = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       send_space;
    logic       send_request;
    logic [7:0] overflow_count;
    logic       send_refused;
  } out_item_t;

  // Memory requests from the pointer logic, one per accepted transaction
  typedef struct packed {
    logic       tx_we;
    ptr_t       tx_waddr;
    logic       tx_re;
    ptr_t       tx_raddr;
    logic       rx_we;
    ptr_t       rx_waddr;
    logic       rx_re;
    ptr_t       rx_raddr;
    logic [7:0] wdata;
  } mem_req_t;

  // Status after the step; byte comes later from the memory read
  typedef struct packed {
    logic       pop_tx;
    logic       pop_rx;
    logic       send_space;
    logic       send_request;
    logic [7:0] overflow_count;
    logic       send_refused;
  } step_info_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == LAST_POS) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

// File: design/utrb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module utrb_ram #(
  parameter int DEPTH_P = 128,
  parameter int WIDTH_P = 8
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH_P)-1:0] waddr,
  input  logic [WIDTH_P-1:0]         wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH_P)-1:0] raddr,
  output logic [WIDTH_P-1:0]         rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];
  logic [WIDTH_P-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/utrb_ctrl.sv
// Ring pointers, request flag and overflow counter for both buffers.
`include "uart_tx_rx_ring_buffers_unit_defines.svh"

module utrb_ctrl import utrb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  in_item_t   item,
  output mem_req_t   mem_req,
  output step_info_t step
);

  ptr_t       tx_wp_r, tx_wp_nxt;
  ptr_t       tx_rp_r, tx_rp_nxt;
  ptr_t       rx_wp_r, rx_wp_nxt;
  ptr_t       rx_rp_r, rx_rp_nxt;
  logic [7:0] drop_r, drop_nxt;
  logic       req_r, req_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wp_r <= '0;
      tx_rp_r <= '0;
      rx_wp_r <= '0;
      rx_rp_r <= '0;
      drop_r  <= '0;
      req_r   <= 1'b0;
    end else begin
      tx_wp_r <= tx_wp_nxt;
      tx_rp_r <= tx_rp_nxt;
      rx_wp_r <= rx_wp_nxt;
      rx_rp_r <= rx_rp_nxt;
      drop_r  <= drop_nxt;
      req_r   <= req_nxt;
    end
  end

  always_comb begin
    tx_wp_nxt = tx_wp_r;
    tx_rp_nxt = tx_rp_r;
    rx_wp_nxt = rx_wp_r;
    rx_rp_nxt = rx_rp_r;
    drop_nxt  = drop_r;
    req_nxt   = req_r;

    mem_req          = '0;
    mem_req.tx_waddr = tx_wp_r;
    mem_req.tx_raddr = tx_rp_r;
    mem_req.rx_waddr = rx_wp_r;
    mem_req.rx_raddr = rx_rp_r;
    mem_req.wdata    = item.in_byte;

    step = '0;

    if (acc) begin
      case (item.command)
        CMD_SEND: begin
          if (ptr_inc(tx_wp_r) == tx_rp_r) begin
            step.send_refused = 1'b1;  // full: drop, flag untouched
          end else begin
            mem_req.tx_we = 1'b1;
            tx_wp_nxt     = ptr_inc(tx_wp_r);
            req_nxt       = 1'b1;
          end
        end
        CMD_READ: begin
          if (rx_wp_r != rx_rp_r) begin
            mem_req.rx_re = 1'b1;
            step.pop_rx   = 1'b1;
            rx_rp_nxt     = ptr_inc(rx_rp_r);
          end
        end
        CMD_TICK: begin
          if (tx_wp_r != tx_rp_r) begin
            mem_req.tx_re = 1'b1;
            step.pop_tx   = 1'b1;
            tx_rp_nxt     = ptr_inc(tx_rp_r);
          end
          if (tx_wp_r == tx_rp_nxt) begin
            req_nxt = 1'b0;
          end
        end
        CMD_RECV: begin
          if (ptr_inc(rx_wp_r) == rx_rp_r) begin
            drop_nxt = drop_r + 8'd1;
          end else begin
            mem_req.rx_we = 1'b1;
            rx_wp_nxt     = ptr_inc(rx_wp_r);
          end
        end
        default: begin
        end
      endcase
    end

    step.send_space     = (ptr_inc(tx_wp_nxt) != tx_rp_nxt);
    step.send_request   = req_nxt;
    step.overflow_count = drop_nxt;
  end

  // Request flag tracks transmit occupancy exactly
  `UTRB_ASSERT_IMPL(a_req_tracks_tx, 1'b1, req_r == (tx_wp_r != tx_rp_r))
  // A refused send leaves the transmit side alone
  `UTRB_ASSERT_NEXT(a_refused_no_change, step.send_refused, $stable(tx_wp_r) && $stable(req_r))
  // Pops only from a non-empty buffer
  `UTRB_ASSERT_IMPL(a_rx_pop_nonempty, mem_req.rx_re, rx_wp_r != rx_rp_r)

endmodule

// File: design/uart_tx_rx_ring_buffers_unit.sv
// Top level: CPU-side and line-side ring buffer pair, one result per transaction.
//
// Two byte FIFOs of DEPTH entries (DEPTH-1 usable, one slot kept free).
// Each input transaction carries a command: CPU send pushes into the
// transmit FIFO (refused and flagged when full), CPU read pops the receive
// FIFO, a transmitter-ready tick pops the transmit FIFO and drops the
// request once it is empty, and a line byte pushes into the receive FIFO
// (dropped when full, counted in a wrapping 8-bit overflow counter).
// Every input transaction yields exactly one output transaction carrying
// the popped byte (zero when nothing was popped) and the status after the
// step. Throughput is one transaction per cycle while the output is not
// stalled. The result is registered first by the FIFO RAM read stage,
// then by the output register. Storage is two synchronous RAMs with no
// reset; no clearing pass is needed since an entry is only read after
// being written.
`include "uart_tx_rx_ring_buffers_unit_defines.svh"

module uart_tx_rx_ring_buffers_unit import utrb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic       acc;
  logic       out_adv;
  mem_req_t   mem_req;
  step_info_t step;
  logic [7:0] tx_rdata;
  logic [7:0] rx_rdata;

  // Stage 1: transaction accepted, RAM read in flight
  logic       pend_valid_r, pend_valid_nxt;
  step_info_t pend_r;

  // Stage 2: output register
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;
  out_item_t  out_build;

  // Output stage can take a new transaction when empty or draining.
  assign out_adv  = !out_valid_r || !out_stall;
  // Hold input only while the RAM-read stage is stuck behind the output.
  assign in_stall = pend_valid_r && !out_adv;
  assign acc      = in_valid && !in_stall;

  utrb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .item    (in_data),
    .mem_req (mem_req),
    .step    (step)
  );

  // RAM read data only changes on a new accept, so it holds while stalled.
  utrb_ram #(.DEPTH_P(DEPTH), .WIDTH_P(8)) u_tx_ram (
    .clk   (clk),
    .we    (mem_req.tx_we),
    .waddr (mem_req.tx_waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.tx_re),
    .raddr (mem_req.tx_raddr),
    .rdata (tx_rdata)
  );

  utrb_ram #(.DEPTH_P(DEPTH), .WIDTH_P(8)) u_rx_ram (
    .clk   (clk),
    .we    (mem_req.rx_we),
    .waddr (mem_req.rx_waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.rx_re),
    .raddr (mem_req.rx_raddr),
    .rdata (rx_rdata)
  );

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (acc) begin
      pend_valid_nxt = 1'b1;
    end else if (out_adv) begin
      pend_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_adv ? pend_valid_r : out_valid_r;

    out_build                = '0;
    out_build.out_valid      = pend_r.pop_tx || pend_r.pop_rx;
    out_build.out_byte       = pend_r.pop_tx ? tx_rdata :
                               pend_r.pop_rx ? rx_rdata : 8'd0;
    out_build.send_space     = pend_r.send_space;
    out_build.send_request   = pend_r.send_request;
    out_build.overflow_count = pend_r.overflow_count;
    out_build.send_refused   = pend_r.send_refused;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_r <= step;
    end
    if (out_adv && pend_valid_r) begin
      out_data_r <= out_build;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Stall only arises with a transaction waiting for the output stage
  `UTRB_ASSERT_IMPL(a_stall_needs_pend, in_stall, pend_valid_r && out_valid_r)
  // A popped byte comes from exactly one FIFO
  `UTRB_ASSERT_IMPL(a_one_pop, pend_valid_r, !(pend_r.pop_tx && pend_r.pop_rx))
  // No byte reported without a pop
  `UTRB_ASSERT_IMPL(a_zero_byte, out_valid_r && !out_data_r.out_valid, out_data_r.out_byte == 8'd0)

endmodule
